@@ sv/bpa_pkg.sv @@
// -----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared widths, codes, payload words and controller/datapath interface types.
// -----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MAX_PAGES = 4096;
   localparam int PAGE_W    = $clog2(MAX_PAGES);
   localparam int COUNT_W   = PAGE_W + 1;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;

   // map storage: one memory row holds the used bits of WORD_W pages
   localparam int WORD_W    = 64;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int NUM_WORDS = MAX_PAGES / WORD_W;
   localparam int WADDR_W   = $clog2(NUM_WORDS);

   localparam logic [COUNT_W-1:0] PAGE_LIMIT = COUNT_W'(MAX_PAGES);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RESERVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_OOM      = 2'd1,
      ST_NOT_USED = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      WR_ZERO,
      WR_SET,
      WR_CLEAR
   } wr_op_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_SCAN_RD,
      S_SCAN_EVAL,
      S_CHK_RD,
      S_CHK_EVAL,
      S_WR_RD,
      S_WR_EVAL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [PAGE_W-1:0]  start_page;
      logic [COUNT_W-1:0] page_count;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   first_page;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       w_inc;
      logic       scan_step;
      logic       scan_hit;
      logic       rng_first;
      logic       wr_en;
      wr_op_type  wr_op;
      logic       st_wr;
      status_type st_code;
      logic       rsp_load;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             count_zero;
      logic             oob;
      logic             empty;
      logic             found;
      logic             word_last;
      logic             rng_last;
      logic             check_ok;
   } dp_stat_type;

endpackage

@@ sv/bpa_dp.sv @@
// -----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Page map memory, first-fit word scanner and range mask read-modify-write.
// -----------------------------------------------------------------------------
module bpa_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  bpa_pkg::req_type             req_data,
   input  logic [bpa_pkg::COUNT_W-1:0]  lim,
   input  bpa_pkg::dp_cmd_type          dp_cmd,
   output bpa_pkg::dp_stat_type         dp_stat,
   output bpa_pkg::rsp_type             rsp_data
);
   import bpa_pkg::*;

   localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
   localparam int LW_W = COUNT_W - BIT_W;

   logic [WORD_W-1:0]  mem [NUM_WORDS];
   logic [WORD_W-1:0]  rdata_ff;
   logic [WORD_W-1:0]  wdata;

   logic [WADDR_W-1:0] w_ff, w_in;
   logic [CMD_W-1:0]   command_ff;
   logic [COUNT_W-1:0] need_ff, carry_ff, hi_ff;
   logic [PAGE_W-1:0]  lo_ff;
   logic               count_zero_ff, oob_ff;
   status_type         st_ff;
   logic [PAGE_W-1:0]  first_ff;
   rsp_type            rsp_ff;

   // load-time range
   logic [COUNT_W:0]   sum;
   logic               oob_load;
   logic [COUNT_W-1:0] hi_load;

   // range masks
   logic [WADDR_W-1:0] lo_word, hi_word;
   logic [BIT_W-1:0]   lo_bit, hi_bit;
   logic [COUNT_W-1:0] hi_m1;
   logic [WORD_W-1:0]  lo_mask, hi_mask, rmask;

   // scanner
   logic [LW_W-1:0]    lim_word, w_ext;
   logic [BIT_W-1:0]   lim_bit;
   logic [WORD_W-1:0]  vmask, free_v, hit;
   logic [BIT_W:0]     hl [BIT_W+1][WORD_W];
   logic [COUNT_W-1:0] run [WORD_W];
   logic               found;
   logic [BIT_W-1:0]   hit_idx;
   logic [PAGE_W-1:0]  page_end, base;
   logic [COUNT_W-1:0] carry_next;

   always_comb begin
      sum      = (COUNT_W+1)'(req_data.start_page) + (COUNT_W+1)'(req_data.page_count);
      oob_load = sum > (COUNT_W+1)'(lim);
      hi_load  = oob_load ? lim : sum[COUNT_W-1:0];
   end

   // word mask of the pages in [lo, hi)
   always_comb begin
      lo_word = lo_ff[PAGE_W-1:BIT_W];
      lo_bit  = lo_ff[BIT_W-1:0];
      hi_m1   = hi_ff - COUNT_W'(1);
      hi_word = hi_m1[PAGE_W-1:BIT_W];
      hi_bit  = hi_m1[BIT_W-1:0];
      if (w_ff > lo_word) begin
         lo_mask = ONES;
      end else if (w_ff == lo_word) begin
         lo_mask = ONES << lo_bit;
      end else begin
         lo_mask = '0;
      end
      if (w_ff < hi_word) begin
         hi_mask = ONES;
      end else if (w_ff == hi_word) begin
         hi_mask = ONES >> (BIT_W'(WORD_W - 1) - hi_bit);
      end else begin
         hi_mask = '0;
      end
      rmask = lo_mask & hi_mask;
   end

   // pages at or past the managed limit count as used
   always_comb begin
      lim_word = lim[COUNT_W-1:BIT_W];
      lim_bit  = lim[BIT_W-1:0];
      w_ext    = LW_W'(w_ff);
      if (w_ext < lim_word) begin
         vmask = ONES;
      end else if (w_ext == lim_word) begin
         vmask = ~(ONES << lim_bit);
      end else begin
         vmask = '0;
      end
      free_v = ~rdata_ff & vmask;
   end

   // prefix search: position of the last used page at or below each bit
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         hl[0][i] = free_v[i] ? '0 : {1'b1, BIT_W'(i)};
      end
      for (int s = 0; s < BIT_W; s++) begin
         for (int i = 0; i < WORD_W; i++) begin
            if (i >= (1 << s) && !hl[s][i][BIT_W]) begin
               hl[s+1][i] = hl[s][i - (1 << s)];
            end else begin
               hl[s+1][i] = hl[s][i];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         if (hl[BIT_W][i][BIT_W]) begin
            run[i] = COUNT_W'(BIT_W'(i) - hl[BIT_W][i][BIT_W-1:0]);
         end else begin
            run[i] = carry_ff + COUNT_W'(i) + COUNT_W'(1);
         end
         hit[i] = free_v[i] && (run[i] >= need_ff);
      end
      found   = |hit;
      hit_idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = BIT_W'(i);
         end
      end
      page_end = {w_ff, hit_idx};
      base     = PAGE_W'(COUNT_W'(page_end) + COUNT_W'(1) - need_ff);
      if (hl[BIT_W][WORD_W-1][BIT_W]) begin
         carry_next = COUNT_W'(BIT_W'(WORD_W - 1) - hl[BIT_W][WORD_W-1][BIT_W-1:0]);
      end else begin
         carry_next = carry_ff + COUNT_W'(WORD_W);
      end
   end

   always_comb begin
      priority if (dp_cmd.load) begin
         w_in = '0;
      end else if (dp_cmd.scan_hit) begin
         w_in = base[PAGE_W-1:BIT_W];
      end else if (dp_cmd.rng_first) begin
         w_in = lo_word;
      end else if (dp_cmd.w_inc) begin
         w_in = w_ff + WADDR_W'(1);
      end else begin
         w_in = w_ff;
      end
   end

   always_comb begin
      unique case (dp_cmd.wr_op)
         WR_ZERO:  wdata = '0;
         WR_SET:   wdata = rdata_ff | rmask;
         WR_CLEAR: wdata = rdata_ff & ~rmask;
         default:  wdata = rdata_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else begin
         w_ff <= w_in;
      end
   end

   // map memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (dp_cmd.wr_en) begin
         mem[w_ff] <= wdata;
      end
      rdata_ff <= mem[w_ff];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         command_ff    <= req_data.command;
         need_ff       <= (req_data.page_count == '0) ? COUNT_W'(1) : req_data.page_count;
         lo_ff         <= req_data.start_page;
         hi_ff         <= hi_load;
         oob_ff        <= oob_load;
         count_zero_ff <= (req_data.page_count == '0);
         carry_ff      <= '0;
         st_ff         <= ST_OK;
         first_ff      <= '0;
      end else begin
         if (dp_cmd.scan_step) begin
            carry_ff <= carry_next;
         end
         if (dp_cmd.scan_hit) begin
            lo_ff    <= base;
            hi_ff    <= COUNT_W'(page_end) + COUNT_W'(1);
            first_ff <= base;
         end
         if (dp_cmd.st_wr) begin
            st_ff <= dp_cmd.st_code;
         end
      end
      if (dp_cmd.rsp_load) begin
         rsp_ff.status     <= st_ff;
         rsp_ff.first_page <= first_ff;
      end
   end

   always_comb begin
      dp_stat.command    = command_ff;
      dp_stat.count_zero = count_zero_ff;
      dp_stat.oob        = oob_ff;
      dp_stat.empty      = COUNT_W'(lo_ff) >= hi_ff;
      dp_stat.found      = found;
      dp_stat.word_last  = (w_ff == WADDR_W'(NUM_WORDS - 1));
      dp_stat.rng_last   = (w_ff == hi_word);
      dp_stat.check_ok   = ((rdata_ff & rmask) == rmask);
   end

   assign rsp_data = rsp_ff;

endmodule

@@ sv/bpa_ctrl.sv @@
// -----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences clearing, scanning, range check and range update, one map word at a time.
// -----------------------------------------------------------------------------
module bpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bpa_pkg::dp_stat_type   dp_stat,
   output bpa_pkg::dp_cmd_type    dp_cmd
);
   import bpa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      dp_cmd         = '0;
      dp_cmd.wr_op   = WR_ZERO;
      dp_cmd.st_code = ST_OK;
      unique case (state_ff)
         S_CLEAR: begin
            dp_cmd.wr_en = 1'b1;
            dp_cmd.w_inc = 1'b1;
            if (dp_stat.word_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (dp_stat.command)
               CMD_ALLOC: begin
                  state_in = S_SCAN_RD;
               end
               CMD_FREE: begin
                  priority if (dp_stat.count_zero) begin
                     state_in = S_RESP;
                  end else if (dp_stat.oob) begin
                     dp_cmd.st_wr   = 1'b1;
                     dp_cmd.st_code = ST_RANGE;
                     state_in       = S_RESP;
                  end else begin
                     dp_cmd.rng_first = 1'b1;
                     state_in         = S_CHK_RD;
                  end
               end
               CMD_RESERVE: begin
                  if (dp_stat.empty) begin
                     state_in = S_RESP;
                  end else begin
                     dp_cmd.rng_first = 1'b1;
                     state_in         = S_WR_RD;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_EVAL;
         end
         S_SCAN_EVAL: begin
            priority if (dp_stat.found) begin
               dp_cmd.scan_hit = 1'b1;
               state_in        = S_WR_RD;
            end else if (dp_stat.word_last) begin
               dp_cmd.st_wr   = 1'b1;
               dp_cmd.st_code = ST_OOM;
               state_in       = S_RESP;
            end else begin
               dp_cmd.scan_step = 1'b1;
               dp_cmd.w_inc     = 1'b1;
               state_in         = S_SCAN_RD;
            end
         end
         S_CHK_RD: begin
            state_in = S_CHK_EVAL;
         end
         S_CHK_EVAL: begin
            priority if (!dp_stat.check_ok) begin
               dp_cmd.st_wr   = 1'b1;
               dp_cmd.st_code = ST_NOT_USED;
               state_in       = S_RESP;
            end else if (dp_stat.rng_last) begin
               dp_cmd.rng_first = 1'b1;
               state_in         = S_WR_RD;
            end else begin
               dp_cmd.w_inc = 1'b1;
               state_in     = S_CHK_RD;
            end
         end
         S_WR_RD: begin
            state_in = S_WR_EVAL;
         end
         S_WR_EVAL: begin
            dp_cmd.wr_en = 1'b1;
            dp_cmd.wr_op = (dp_stat.command == CMD_FREE) ? WR_CLEAR : WR_SET;
            if (dp_stat.rng_last) begin
               state_in = S_RESP;
            end else begin
               dp_cmd.w_inc = 1'b1;
               state_in     = S_WR_RD;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold the result word until taken; a new one lands only in a free slot
   always_comb begin
      if (dp_cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/bitmap_page_allocator_top.sv @@
// -----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit allocate, checked free and clipped reserve over a used-page map.
// -----------------------------------------------------------------------------
// Allocate scans map words (up to 64), then marks the words of the run;
//   free checks the words of the range, then clears them; reserve marks
//   each word touched; every command also passes decode and response states.
// Throughput: one command at a time; the map memory port (one row of 64 pages,
//   read then written) sets the pace.
// Reset: synchronous; a clearing pass over all 64 map words zeroes the map
//   before the first request word is taken. managed_pages resets to 4096.
module bitmap_page_allocator_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bpa_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bpa_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [bpa_pkg::COUNT_W-1:0]  csr_wr_data
);
   import bpa_pkg::*;

   logic [COUNT_W-1:0] managed_pages_ff, managed_pages_in;
   logic [COUNT_W-1:0] lim;
   dp_cmd_type         dp_cmd;
   dp_stat_type        dp_stat;

   // managed page count register; the user must write it only while idle, the block does not enforce this
   always_comb begin
      if (csr_wr_en) begin
         managed_pages_in = csr_wr_data;
      end else begin
         managed_pages_in = managed_pages_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         managed_pages_ff <= PAGE_LIMIT;
      end else begin
         managed_pages_ff <= managed_pages_in;
      end
   end

   // clamp to the map size; pages beyond stay in the map but are not visible
   assign lim = (managed_pages_ff > PAGE_LIMIT) ? PAGE_LIMIT : managed_pages_ff;

   // controller: walks the map one memory word at a time
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   // datapath: map memory, run scanner, range masks, result register
   bpa_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .lim      (lim),
      .dp_cmd   (dp_cmd),
      .dp_stat  (dp_stat),
      .rsp_data (rsp_data)
   );

   // one command in flight: a taken request closes the input
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in flight");

   // the clearing pass blocks requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request port open during map clearing");

   // only a granted allocation carries a page number
   a_first_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |-> rsp_data.first_page == '0)
      else $error("failed command returned a nonzero first page");

endmodule

@@ dv/bitmap_page_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate, free, reserve and unused command words through the request
// channel and checks every response word against a shadow page map kept here.
// The managed page count is changed between phases while the block is idle.
// -----------------------------------------------------------------------------
module bitmap_page_allocator_top_tb;
   import bpa_pkg::*;

   // command code that the block must ignore
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // hard stop, far above the slowest correct run
   localparam int CYCLE_LIMIT = 4_000_000;
   // quiet cycles at the end to catch stray response words
   localparam int TAIL_CYCLES = 400;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data = '0;

   bitmap_page_allocator_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow state of the allocator: used bit per page and the managed count
   // ---------------------------------------------------------------------------
   logic [MAX_PAGES-1:0] used_map = '0;
   int                   managed_cfg = MAX_PAGES;

   req_type pending_reqs[$];    // words waiting for the driver
   rsp_type expected_rsps[$];   // predicted response words, oldest first
   int      outstanding = 0;    // words queued but not yet accepted

   int error_count   = 0;
   int cycle_count   = 0;
   int checked_count = 0;
   int setting_count = 0;
   int n_alloc = 0, n_free = 0, n_reserve = 0, n_unused = 0;
   int n_granted = 0, n_oom = 0, n_free_err = 0;

   logic req_taken = 1'b0;      // request word accepted at the last rising edge
   int   req_gap   = 0;
   int   rsp_stall = 0;

   task automatic report_error(string msg);
      error_count++;
      $display("[%0t] ERROR: %s", $time, msg);
   endtask

   // Pages that actually count: the register clips at the map size.
   function automatic int active_limit();
      return (managed_cfg > MAX_PAGES) ? MAX_PAGES : managed_cfg;
   endfunction

   // Apply one command word to the shadow map and return the response it
   // must produce.
   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      int      lim, need, run, base, start, count, p, k;
      bit      granted, fault;
      o.status     = ST_OK;
      o.first_page = '0;
      lim   = active_limit();
      start = r.start_page;
      count = r.page_count;
      case (r.command)
         CMD_ALLOC: begin
            n_alloc++;
            // zero-length request is served as one page
            need    = (count == 0) ? 1 : count;
            run     = 0;
            granted = 1'b0;
            for (p = 0; p < lim && !granted; p++) begin
               if (used_map[p]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run >= need) begin
                     base = p + 1 - run;
                     for (k = 0; k < run; k++) used_map[base + k] = 1'b1;
                     o.first_page = PAGE_W'(base);
                     granted = 1'b1;
                  end
               end
            end
            if (granted) begin
               n_granted++;
            end else begin
               o.status = ST_OOM;
               n_oom++;
            end
         end
         CMD_FREE: begin
            n_free++;
            if (count == 0) begin
               o.status = ST_OK;
            end else if (start + count > lim) begin
               // range check wins over the used check
               o.status = ST_RANGE;
            end else begin
               fault = 1'b0;
               for (k = 0; k < count; k++) if (!used_map[start + k]) fault = 1'b1;
               if (fault) begin
                  o.status = ST_NOT_USED;
               end else begin
                  for (k = 0; k < count; k++) used_map[start + k] = 1'b0;
               end
            end
            if (o.status != ST_OK) n_free_err++;
         end
         CMD_RESERVE: begin
            n_reserve++;
            // clip at the end of the managed pages
            for (k = 0; k < count && start + k < lim; k++) used_map[start + k] = 1'b1;
         end
         default: begin
            n_unused++;
         end
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Scoreboard: check response words, then record accepted request words
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      req_taken <= req_valid && (req_ready === 1'b1);
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_error($sformatf("response word with nothing expected (status %0d, page %0d)",
                                      rsp_data.status, rsp_data.first_page));
            end else begin
               want = expected_rsps.pop_front();
               checked_count++;
               if (rsp_data.status !== want.status)
                  report_error($sformatf("status: got %0d, expected %0d",
                                         rsp_data.status, want.status));
               if (rsp_data.first_page !== want.first_page)
                  report_error($sformatf("first_page: got %0d, expected %0d",
                                         rsp_data.first_page, want.first_page));
            end
         end
         if (req_valid && req_ready === 1'b1) begin
            expected_rsps.push_back(predict_rsp(req_data));
            outstanding--;
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_rsps.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Gap length: mostly none, often a few cycles, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: hold a word until accepted, then idle for its gap
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold valid and payload until the handshake
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap   <= req_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         req_valid <= 1'b1;
         req_data  <= pending_reqs.pop_front();
         req_gap   <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response side: stall at random, with long runs of ready in between.
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_stall <= pick_gap();
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic req_type make_req(logic [CMD_W-1:0] cmd, int start, int count);
      req_type r;
      r.command    = cmd;
      r.start_page = PAGE_W'(start);
      r.page_count = COUNT_W'(count);
      return r;
   endfunction

   task automatic queue_req(req_type r);
      pending_reqs.push_back(r);
      outstanding++;
   endtask

   // Block until every queued word has been accepted and answered.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (outstanding != 0 || expected_rsps.size() != 0);
   endtask

   // Only called while idle, so the shadow copy can change at once.
   task automatic write_managed_pages(int value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(value);
      managed_cfg  = value;
      setting_count++;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Page inside the managed range, or any page when nothing is managed.
   function automatic int any_page(int lim);
      if (lim == 0) return $urandom_range(0, MAX_PAGES - 1);
      return $urandom_range(0, lim - 1);
   endfunction

   // Pick a run of used pages from the shadow map, for a free that should pass.
   function automatic bit find_used_run(output int first, output int len);
      int lim, p, k, want, tier;
      bit hit;
      lim   = active_limit();
      hit   = 1'b0;
      first = 0;
      len   = 0;
      if (lim == 0) return 1'b0;
      p = $urandom_range(0, lim - 1);
      for (k = 0; k < lim && !hit; k++) begin
         if (used_map[(p + k) % lim]) begin
            hit   = 1'b1;
            first = (p + k) % lim;
         end
      end
      if (!hit) return 1'b0;
      tier = $urandom_range(0, 99);
      if (tier < 50)      want = $urandom_range(1, 16);
      else if (tier < 85) want = $urandom_range(1, 128);
      else                want = MAX_PAGES;
      while (len < want && first + len < lim && used_map[first + len]) len++;
      return 1'b1;
   endfunction

   // One batch of random words built from the current (idle) map, then drain.
   task automatic run_batch();
      int      n, i, pick, lim, first, len, tier;
      req_type r;
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++) begin
         lim  = active_limit();
         pick = $urandom_range(0, 99);
         // crowded map: turn allocations into frees
         if ($countones(used_map) * 4 > lim * 3 && pick < 35) pick = pick + 35;
         tier = $urandom_range(0, 99);
         if (pick < 35) begin
            if (tier < 55)      len = $urandom_range(0, 8);
            else if (tier < 85) len = $urandom_range(9, 64);
            else if (tier < 97) len = $urandom_range(65, 512);
            else                len = $urandom_range(513, (1 << COUNT_W) - 1);
            r = make_req(CMD_ALLOC, $urandom(), len);
         end else if (pick < 65) begin
            if (find_used_run(first, len)) begin
               // now and then spill one page past the run
               if (tier < 10) len++;
               r = make_req(CMD_FREE, first, len);
            end else begin
               r = make_req(CMD_ALLOC, $urandom(), $urandom_range(0, 8));
            end
         end else if (pick < 75) begin
            if (tier < 5) len = $urandom_range(0, (1 << COUNT_W) - 1);
            else          len = $urandom_range(0, 64);
            if (tier < 50) first = any_page(lim);
            else           first = $urandom_range(0, MAX_PAGES - 1);
            r = make_req(CMD_FREE, first, len);
         end else if (pick < 92) begin
            if (tier < 75) begin
               r = make_req(CMD_RESERVE, any_page(lim), $urandom_range(0, 32));
            end else if (tier < 90 && lim > 16) begin
               r = make_req(CMD_RESERVE, lim - $urandom_range(1, 16), $urandom_range(1, 64));
            end else if (tier < 95) begin
               r = make_req(CMD_RESERVE, $urandom_range(0, MAX_PAGES - 1), $urandom_range(0, 64));
            end else begin
               r = make_req(CMD_RESERVE, $urandom_range(0, MAX_PAGES - 1),
                            $urandom_range(0, (1 << COUNT_W) - 1));
            end
         end else begin
            r = make_req(CMD_UNUSED, $urandom(), $urandom());
         end
         queue_req(r);
      end
      wait_until_drained();
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   int phase_settings[10] = '{0, 8, 4096, 8191, 1, 1000, 64, 0, 2500, 4096};

   initial begin
      int ph, target, sent_before;
      // hold reset, then release it at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset setting of 4096 managed pages.
      queue_req(make_req(CMD_ALLOC,   0,    0));     // zero length acts as one page
      queue_req(make_req(CMD_ALLOC,   4095, 1));
      queue_req(make_req(CMD_ALLOC,   0,    4096));  // no run long enough
      queue_req(make_req(CMD_FREE,    0,    0));     // zero-length free
      queue_req(make_req(CMD_FREE,    4095, 2));     // runs past the end
      queue_req(make_req(CMD_FREE,    10,   1));     // page not in use
      queue_req(make_req(CMD_FREE,    0,    2));
      queue_req(make_req(CMD_ALLOC,   0,    4096));  // whole map
      queue_req(make_req(CMD_ALLOC,   0,    1));     // map full
      queue_req(make_req(CMD_FREE,    0,    4096));
      queue_req(make_req(CMD_RESERVE, 4090, 100));   // clipped at the end
      queue_req(make_req(CMD_RESERVE, 5,    0));     // zero-length reserve
      queue_req(make_req(CMD_UNUSED,  4095, 8191));  // ignored command
      queue_req(make_req(CMD_FREE,    4090, 6));
      queue_req(make_req(CMD_RESERVE, 0,    4096));
      queue_req(make_req(CMD_FREE,    4095, 1));
      queue_req(make_req(CMD_ALLOC,   0,    1));     // only the last page is free
      queue_req(make_req(CMD_FREE,    0,    8191));  // widest count, out of range
      queue_req(make_req(CMD_ALLOC,   0,    8191));
      queue_req(make_req(CMD_FREE,    0,    4096));
      queue_req(make_req(CMD_RESERVE, 10,   10));
      queue_req(make_req(CMD_ALLOC,   0,    15));    // first fit skips the hole
      queue_req(make_req(CMD_RESERVE, 0,    8191));  // clipped to the map
      queue_req(make_req(CMD_FREE,    0,    4096));
      wait_until_drained();

      // Random phases; each setting change happens only while idle.
      for (ph = 0; ph < 10; ph++) begin
         target = phase_settings[ph];
         if (ph == 7) target = $urandom_range(9, MAX_PAGES - 1);
         write_managed_pages(target);
         sent_before = n_alloc + n_free + n_reserve + n_unused;
         while (n_alloc + n_free + n_reserve + n_unused - sent_before < ((target < 16) ? 40 : 160))
            run_batch();
      end

      wait_until_drained();
      // let any stray response word show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_error($sformatf("%0d response words never arrived", expected_rsps.size()));

      $display("Ran %0d commands (alloc %0d, free %0d, reserve %0d, unused %0d) over %0d settings",
               n_alloc + n_free + n_reserve + n_unused, n_alloc, n_free, n_reserve, n_unused,
               setting_count + 1);
      $display("Checked %0d responses: %0d grants, %0d out of memory, %0d rejected frees",
               checked_count, n_granted, n_oom, n_free_err);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/bpa_pkg.sv
sv/bpa_dp.sv
sv/bpa_ctrl.sv
sv/bitmap_page_allocator_top.sv
dv/bitmap_page_allocator_top_tb.sv
